// ----- rtl/dmwbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dmwbc_pkg
// shared widths, parameter defaults and transaction kind codes for the
// direct-mapped write-back cache
// ----------------------------------------------------------------------------
package dmwbc_pkg;

  localparam int DATA_W = 16;
  localparam int ADDR_W = 16;
  localparam int KIND_W = 2;
  localparam int CNT_W  = 32;

  localparam int DEF_CACHE_LINES  = 32;
  localparam int DEF_MEMORY_WORDS = 65536;

  // transaction kinds, code 3 is unused and does nothing
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PRELOAD = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/direct_mapped_write_back_cache.sv -----
`timescale 1ns / 1ps
`default_nettype none
// sequence: after input acceptance S_AM and S_QL reduce the address, S_IL
//   forms the line index and does the synchronous read of line store and backing memory,
//   and S_EXEC, which out_stall holds while a result waits, does the single
//   read-modify-write step; in_stall holds off new transactions until S_EXEC is left
// reset: after rst_n a clearing pass over max(CACHE_LINES, MEMORY_WORDS) addresses
//   zeroes the line store and backing memory; in_stall stays high until done
// ----------------------------------------------------------------------------
// direct_mapped_write_back_cache
// direct-mapped, write-back, write-allocate cache of one-word lines in front
// of an internal backing memory, with saturating traffic and hit counters
// ----------------------------------------------------------------------------
module direct_mapped_write_back_cache #(
  parameter int CACHE_LINES  = dmwbc_pkg::DEF_CACHE_LINES,
  parameter int MEMORY_WORDS = dmwbc_pkg::DEF_MEMORY_WORDS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [dmwbc_pkg::KIND_W-1:0]  in_kind,
  input  wire logic [dmwbc_pkg::ADDR_W-1:0]  in_address,
  input  wire logic [dmwbc_pkg::DATA_W-1:0]  in_write_data,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [dmwbc_pkg::DATA_W-1:0]       out_read_data,
  output logic                               out_was_hit,
  output logic                               out_did_write_back,
  output logic [dmwbc_pkg::CNT_W-1:0]        out_memory_read_count,
  output logic [dmwbc_pkg::CNT_W-1:0]        out_memory_write_count,
  output logic [dmwbc_pkg::CNT_W-1:0]        out_hit_count,
  output logic [dmwbc_pkg::CNT_W-1:0]        out_miss_count
);

  import dmwbc_pkg::*;

  // address and index widths
  localparam int AW = $clog2(MEMORY_WORDS);
  localparam int IW = $clog2(CACHE_LINES);

  // division by constants through reciprocal multiplication, exact for any
  // 16-bit dividend: shift = 16 + ceil(log2 divisor), multiplier rounded up
  localparam int RCPW  = ADDR_W + 1;
  localparam int PW    = ADDR_W + RCPW;
  localparam int MW_SH = ADDR_W + AW;
  localparam int CL_SH = ADDR_W + IW;
  localparam logic [RCPW-1:0] MW_RCP = RCPW'(((64'd1 << MW_SH) + 64'(MEMORY_WORDS) - 64'd1)
                                            / 64'(MEMORY_WORDS));
  localparam logic [RCPW-1:0] CL_RCP = RCPW'(((64'd1 << CL_SH) + 64'(CACHE_LINES) - 64'd1)
                                            / 64'(CACHE_LINES));

  // quotient widths
  localparam int QMW = ADDR_W + 1 - AW;
  localparam int QLW = (AW + 1 > IW) ? AW + 1 - IW : 1;

  // clearing pass covers both stores
  localparam int CLRN = (CACHE_LINES > MEMORY_WORDS) ? CACHE_LINES : MEMORY_WORDS;
  localparam int CW   = $clog2(CLRN);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // one cache line: the full reduced address stands in for the tag, since
  // lines at the same index have equal tags exactly when addresses match
  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [AW-1:0]     addr;
    logic [DATA_W-1:0] data;
  } line_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,  // zeroing sweep after reset
    S_IDLE  = 6'b000010,  // waiting for a transaction
    S_AM    = 6'b000100,  // address modulo memory size
    S_QL    = 6'b001000,  // line quotient
    S_IL    = 6'b010000,  // line index, memory reads issued
    S_EXEC  = 6'b100000   // read-modify-write and result
  } state_t;

  state_t state_r, state_nxt;

  // latched transaction
  logic [KIND_W-1:0] kind_r;
  logic [ADDR_W-1:0] x_r;
  logic [DATA_W-1:0] wdata_r;

  // address reduction pipeline registers
  logic [QMW-1:0] q1_r;
  logic [AW-1:0]  addr_r;
  logic [QLW-1:0] ql_r;
  logic [IW-1:0]  idx_r;

  logic [PW-1:0]  prod_m;
  logic [PW-1:0]  prod_qm;
  logic [PW-1:0]  prod_l;
  logic [PW-1:0]  prod_ql;
  logic [QMW-1:0] q1_nxt;
  logic [AW-1:0]  addr_nxt;
  logic [QLW-1:0] ql_nxt;
  logic [IW-1:0]  idx_c;

  logic [CW-1:0] clr_cnt_r;

  // memories
  line_t             line_mem [CACHE_LINES];
  logic [DATA_W-1:0] back_mem [MEMORY_WORDS];

  line_t             lm_rdata_r;
  logic [DATA_W-1:0] bm_rdata_r;
  logic              mem_re;
  logic              lm_we;
  logic [IW-1:0]     lm_waddr;
  line_t             lm_wdata;
  logic              bm_we;
  logic [AW-1:0]     bm_waddr;
  logic [DATA_W-1:0] bm_wdata;

  // result and counters
  logic              out_valid_r;
  logic [DATA_W-1:0] rdata_r;
  logic              hit_r;
  logic              wb_r;
  logic [DATA_W-1:0] rdata_c;
  logic              hit_c;
  logic              wb_c;
  logic              inc_rd, inc_wr, inc_hit, inc_miss;
  logic [CNT_W-1:0]  cnt_rd_r, cnt_wr_r, cnt_hit_r, cnt_miss_r;

  logic in_take;
  logic exec_go;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] res;
    res = (v == CNT_MAX) ? v : v + 1'b1;
    return res;
  endfunction

  // handshakes
  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  // the result register is free or being emptied this cycle
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // address reduction: address mod memory size, then mod line count
  always_comb begin
    prod_m   = PW'(in_address) * PW'(MW_RCP);
    q1_nxt   = QMW'(prod_m >> MW_SH);
    prod_qm  = PW'(q1_r) * PW'(MEMORY_WORDS);
    addr_nxt = AW'(PW'(x_r) - prod_qm);
    prod_l   = PW'(addr_r) * PW'(CL_RCP);
    ql_nxt   = QLW'(prod_l >> CL_SH);
    prod_ql  = PW'(ql_r) * PW'(CACHE_LINES);
    idx_c    = IW'(PW'(addr_r) - prod_ql);
  end

  // read-modify-write decision on the fetched line
  always_comb begin
    rdata_c  = '0;
    hit_c    = 1'b0;
    wb_c     = 1'b0;
    inc_rd   = 1'b0;
    inc_wr   = 1'b0;
    inc_hit  = 1'b0;
    inc_miss = 1'b0;
    lm_we    = 1'b0;
    lm_waddr = idx_r;
    lm_wdata = '0;
    bm_we    = 1'b0;
    bm_waddr = lm_rdata_r.addr;
    bm_wdata = lm_rdata_r.data;

    if (state_r == S_CLEAR) begin
      // sweep both stores with zeros
      lm_we    = 1'b1;
      lm_waddr = clr_cnt_r[IW-1:0];
      bm_we    = 1'b1;
      bm_waddr = clr_cnt_r[AW-1:0];
      bm_wdata = '0;
    end else if (exec_go) begin
      case (kind_r)
        KIND_READ: begin
          if (lm_rdata_r.valid && (lm_rdata_r.addr == addr_r)) begin
            hit_c   = 1'b1;
            inc_hit = 1'b1;
            rdata_c = lm_rdata_r.data;
          end else begin
            inc_miss = 1'b1;
            inc_rd   = 1'b1;
            // a valid line that missed has a different tag
            wb_c     = lm_rdata_r.valid && lm_rdata_r.dirty;
            rdata_c  = bm_rdata_r;
            lm_we    = 1'b1;
            lm_wdata = '{valid: 1'b1, dirty: 1'b0, addr: addr_r, data: bm_rdata_r};
          end
        end
        KIND_WRITE: begin
          wb_c     = lm_rdata_r.valid && lm_rdata_r.dirty && (lm_rdata_r.addr != addr_r);
          lm_we    = 1'b1;
          lm_wdata = '{valid: 1'b1, dirty: 1'b1, addr: addr_r, data: wdata_r};
        end
        KIND_PRELOAD: begin
          bm_we    = 1'b1;
          bm_waddr = addr_r;
          bm_wdata = wdata_r;
        end
        default: begin
          // unused kind leaves everything alone
        end
      endcase
      // victim write-back, never in the same transaction as a preload
      if (wb_c) begin
        bm_we  = 1'b1;
        inc_wr = 1'b1;
      end
    end
  end

  // memories read only when the line index is ready
  assign mem_re = (state_r == S_IL);

  always_ff @(posedge clk) begin
    if (lm_we) begin
      line_mem[lm_waddr] <= lm_wdata;
    end
    if (mem_re) begin
      lm_rdata_r <= line_mem[idx_c];
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      back_mem[bm_waddr] <= bm_wdata;
    end
    if (mem_re) begin
      bm_rdata_r <= back_mem[addr_r];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == CW'(CLRN - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_AM;
        end
      end
      S_AM:   state_nxt = S_QL;
      S_QL:   state_nxt = S_IL;
      S_IL:   state_nxt = S_EXEC;
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      cnt_rd_r    <= '0;
      cnt_wr_r    <= '0;
      cnt_hit_r   <= '0;
      cnt_miss_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (inc_rd) begin
        cnt_rd_r <= sat_inc(cnt_rd_r);
      end
      if (inc_wr) begin
        cnt_wr_r <= sat_inc(cnt_wr_r);
      end
      if (inc_hit) begin
        cnt_hit_r <= sat_inc(cnt_hit_r);
      end
      if (inc_miss) begin
        cnt_miss_r <= sat_inc(cnt_miss_r);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r  <= in_kind;
      x_r     <= in_address;
      wdata_r <= in_write_data;
      q1_r    <= q1_nxt;
    end
    if (state_r == S_AM) begin
      addr_r <= addr_nxt;
    end
    if (state_r == S_QL) begin
      ql_r <= ql_nxt;
    end
    if (state_r == S_IL) begin
      idx_r <= idx_c;
    end
    if (exec_go) begin
      rdata_r <= rdata_c;
      hit_r   <= hit_c;
      wb_r    <= wb_c;
    end
  end

  // counters only move when a result is loaded, so they serve the
  // result directly while it waits
  assign out_valid              = out_valid_r;
  assign out_read_data          = rdata_r;
  assign out_was_hit            = hit_r;
  assign out_did_write_back     = wb_r;
  assign out_memory_read_count  = cnt_rd_r;
  assign out_memory_write_count = cnt_wr_r;
  assign out_hit_count          = cnt_hit_r;
  assign out_miss_count         = cnt_miss_r;

endmodule
`default_nettype wire
